// File: src/sitd_pkg.sv
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared constants, types and helper functions for the signed integer to
// decimal ASCII unit.
// ----------------------------------------------------------------------------
package sitd_pkg;

    localparam int WIDTH = 32;
    localparam int BPS   = 4;
    localparam int STEPS = (WIDTH + BPS - 1) / BPS;
    localparam int MAGW  = STEPS * BPS;
    localparam int NDIG  = (WIDTH * 30103) / 100000 + 1;
    localparam int BCDW  = NDIG * 4;
    localparam int IDXW  = $clog2(NDIG);
    localparam int STEPW = $clog2(STEPS);
    localparam int CHW   = 6;

    localparam logic [CHW-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHW-1:0] CH_MINUS = 6'd45;

    typedef struct packed {
        logic            neg;
        logic [IDXW-1:0] top;
        logic [BCDW-1:0] bcd;
    } conv_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } fr_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SIGN,
        BK_DIGIT
    } bk_state_t;

    function automatic logic [BCDW-1:0] dd_step(input logic [BCDW-1:0] bcd,
                                                 input logic [BPS-1:0] bits);
        logic [BCDW-1:0] b;
        b = bcd;
        for (int j = BPS - 1; j >= 0; j--)
        begin
            for (int i = 0; i < NDIG; i++)
            begin
                if (b[4*i +: 4] >= 4'd5)
                begin
                    b[4*i +: 4] = b[4*i +: 4] + 4'd3;
                end
            end
            b = {b[BCDW-2:0], bits[j]};
        end
        return b;
    endfunction

    function automatic logic [IDXW-1:0] top_digit(input logic [BCDW-1:0] bcd);
        logic [IDXW-1:0] t;
        t = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd[4*i +: 4] != 4'd0)
            begin
                t = IDXW'(i);
            end
        end
        return t;
    endfunction

endpackage

// File: src/sitd_front.sv
// ----------------------------------------------------------------------------
// sitd_front
// Takes one integer, splits off the sign, forms the magnitude and converts it
// to packed BCD, four bits per cycle, then hands the result to the queue.
// ----------------------------------------------------------------------------
module sitd_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic signed [sitd_pkg::WIDTH-1:0] value,
    input  logic                             push,
    output logic                             full,
    output logic                             q_push,
    output sitd_pkg::conv_t                  q_wdata,
    input  logic                             q_full
);
    import sitd_pkg::*;

    fr_state_t        state_reg, state_next;
    logic [STEPW-1:0] step_reg, step_next;
    logic             neg_reg, neg_next;
    logic [MAGW-1:0]  mag_reg, mag_next;
    logic [BCDW-1:0]  bcd_reg, bcd_next;
    logic [WIDTH-1:0] val_u;
    logic [WIDTH-1:0] mag_in;
    logic             accept;

    assign val_u  = $unsigned(value);
    assign mag_in = val_u[WIDTH-1] ? (~val_u + 1'b1) : val_u;
    assign accept = push && !full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (push)
                begin
                    state_next = FR_CONV;
                end
            end
            FR_CONV:
            begin
                if (step_reg == '0)
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        full      = 1'b1;
        q_push    = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        case (state_reg)
            FR_IDLE:
            begin
                full = 1'b0;
                if (accept)
                begin
                    step_next = STEPW'(STEPS - 1);
                    neg_next  = val_u[WIDTH-1];
                    mag_next  = MAGW'(mag_in);
                    bcd_next  = '0;
                end
            end
            FR_CONV:
            begin
                bcd_next  = dd_step(bcd_reg, mag_reg[MAGW-1 -: BPS]);
                mag_next  = mag_reg << BPS;
                step_next = step_reg - 1'b1;
            end
            FR_PUSH:
            begin
                q_push = !q_full;
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    assign q_wdata.neg = neg_reg;
    assign q_wdata.top = top_digit(bcd_reg);
    assign q_wdata.bcd = bcd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
    end

endmodule

// File: src/sitd_queue.sv
// ----------------------------------------------------------------------------
// sitd_queue
// Two-entry queue of converted numbers between the front and back parts.
// ----------------------------------------------------------------------------
module sitd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sitd_pkg::conv_t wdata,
    output logic            full,
    input  logic            pop,
    output sitd_pkg::conv_t rdata,
    output logic            empty
);
    import sitd_pkg::*;

    conv_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: src/sitd_back.sv
// ----------------------------------------------------------------------------
// sitd_back
// Takes converted numbers from the queue and emits the sign and digit
// characters, most significant first, through an output register.
// ----------------------------------------------------------------------------
module sitd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  sitd_pkg::conv_t               q_rdata,
    output logic                          q_pop,
    output logic [sitd_pkg::CHW-1:0]      char_code,
    output logic                          last,
    output logic                          empty,
    input  logic                          pop
);
    import sitd_pkg::*;

    bk_state_t       state_reg, state_next;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic [BCDW-1:0] bcd_reg, bcd_next;
    logic            out_valid_reg, out_valid_next;
    logic [CHW-1:0]  char_reg, char_next;
    logic            last_reg, last_next;
    logic            load_out;
    logic            emit;
    logic [CHW-1:0]  emit_char;
    logic            emit_last;
    logic [3:0]      digit;

    assign load_out = !out_valid_reg || pop;
    assign digit    = bcd_reg[idx_reg*4 +: 4];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_rdata.neg ? BK_SIGN : BK_DIGIT;
                end
            end
            BK_SIGN:
            begin
                if (load_out)
                begin
                    state_next = BK_DIGIT;
                end
            end
            BK_DIGIT:
            begin
                if (load_out && (idx_reg == '0))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = CH_ZERO;
        emit_last = 1'b0;
        idx_next  = idx_reg;
        bcd_next  = bcd_reg;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = !q_empty;
                if (!q_empty)
                begin
                    idx_next = q_rdata.top;
                    bcd_next = q_rdata.bcd;
                end
            end
            BK_SIGN:
            begin
                emit      = load_out;
                emit_char = CH_MINUS;
            end
            BK_DIGIT:
            begin
                emit      = load_out;
                emit_char = CH_ZERO + {2'b00, digit};
                emit_last = (idx_reg == '0);
                if (load_out && (idx_reg != '0))
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = emit_char;
            last_next      = emit_last;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign char_code = char_reg;
    assign last      = last_reg;
    assign empty     = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

// File: src/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed two's complement integer to decimal ASCII text.
//
// Input channel: drive value and raise push; the beat is taken when full is
// low. Output channel: while empty is low, char_code and last show the oldest
// character; raise pop to take it. Characters of a number come most
// significant first, a minus sign leading for negative values; last marks
// the final digit. Zero gives a single '0'.
// Flow: the front accepts the number, runs STEPS conversion steps (four bits
// per cycle through the BCD adjust chain) and pushes the result into the
// queue; the back loads it and moves each character to the output register.
// The front takes a new number only once the last is queued; the back emits
// one character per cycle while pop keeps the output free, after a load, and
// takes the next number after the last character. A two-entry queue lets
// the front run ahead. Reset clears all control state; queue and output come
// up empty. When the receiver stalls, the output register holds its beat, the
// queue fills and full rises.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [sitd_pkg::WIDTH-1:0] value,
    input  logic                              push,
    output logic                              full,
    output logic [sitd_pkg::CHW-1:0]          char_code,
    output logic                              last,
    output logic                              empty,
    input  logic                              pop
);
    import sitd_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    conv_t q_wdata;
    conv_t q_rdata;

    sitd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .value   (value),
        .push    (push),
        .full    (full),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full)
    );

    sitd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    sitd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .char_code (char_code),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// File: src/sitd_checker.sv
// ----------------------------------------------------------------------------
// sitd_checker
// Port-level checks on the character stream of the conversion unit.
// ----------------------------------------------------------------------------
module sitd_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     push,
    input logic                     full,
    input logic [sitd_pkg::CHW-1:0] char_code,
    input logic                     last,
    input logic                     empty,
    input logic                     pop
);
    import sitd_pkg::*;

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (char_code == CH_MINUS) ||
                   ((char_code >= CH_ZERO) && (char_code <= CH_ZERO + 6'd9)))
        else $error("char_code outside minus and digits");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (char_code == CH_MINUS)) |-> !last)
        else $error("minus sign flagged as last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(char_code) && $stable(last)))
        else $error("stalled output beat changed");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front took a second number while converting");

endmodule

bind signed_int_to_decimal_ascii_unit sitd_checker u_sitd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .last      (last),
    .empty     (empty),
    .pop       (pop)
);

// File: tb/sitd_text_checker.sv
// ----------------------------------------------------------------------------
// sitd_text_checker
// Watches both channels of the signed integer to decimal ASCII unit. Every
// accepted number is expanded into its expected characters (minus sign,
// digits most significant first, last flag on the final digit). Each character
// beat is compared with the oldest expected character.
// ----------------------------------------------------------------------------
module sitd_text_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [sitd_pkg::WIDTH-1:0] value,
    input  logic                              push,
    input  logic                              full,
    input  logic [sitd_pkg::CHW-1:0]          char_code,
    input  logic                              last,
    input  logic                              empty,
    input  logic                              pop,
    output int                                fail_count,
    output int                                pending,
    output int                                chars_checked
);
    import sitd_pkg::*;

    localparam int RADIX      = 10;
    localparam int MAX_DIGITS = 20;

    typedef struct packed {
        logic [CHW-1:0] code;
        logic           fin;
    } text_char_t;

    text_char_t text_q[$];

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        chars_checked = 0;
    end

    task automatic queue_decimal_text(input logic signed [WIDTH-1:0] v);
        logic [WIDTH-1:0] mag;
        logic [3:0]       dig[MAX_DIGITS];
        logic             neg;
        int               n;
        neg = v[WIDTH-1];
        mag = v;
        if (neg)
        begin
            mag = ~mag + 1'b1;
        end
        n = 0;
        do
        begin
            dig[n] = 4'(mag % RADIX);
            n++;
            mag = mag / RADIX;
        end
        while (mag != 0 && n < MAX_DIGITS);
        if (neg)
        begin
            text_q.push_back('{code: CH_MINUS, fin: 1'b0});
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            text_q.push_back('{code: CH_ZERO + CHW'(dig[i]), fin: (i == 0)});
        end
    endtask

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                chars_checked++;
                if (text_q.size() == 0)
                begin
                    $error("character beat with nothing expected: char_code %0d last %0b",
                           char_code, last);
                    fail_count++;
                end
                else
                begin
                    want = text_q.pop_front();
                    if (char_code !== want.code)
                    begin
                        $error("char_code: expected %0d, got %0d", want.code, char_code);
                        fail_count++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %0b, got %0b", want.fin, last);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                queue_decimal_text(value);
            end
            pending = text_q.size();
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the signed integer to decimal ASCII unit. A short
// directed set covers zero, single digits, powers of ten, both extremes and
// their neighbors; random numbers of mixed magnitude follow under four
// flow-control phases. Checking is done by sitd_text_checker.
// ----------------------------------------------------------------------------
module tb;
    import sitd_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int PER_PHASE   = 63;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic signed [WIDTH-1:0]  value = '0;
    logic                     push  = 1'b0;
    logic                     full;
    logic [CHW-1:0]           char_code;
    logic                     last;
    logic                     empty;
    logic                     pop   = 1'b0;

    int fail_count;
    int pending;
    int chars_checked;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int quiet_cycles = 0;
    int item_count  = 0;
    int neg_count   = 0;

    logic signed [WIDTH-1:0] directed_values[22] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
        32'sd100, 32'sd12345, -32'sd67890, 32'sd999999999, 32'sd1000000000,
        -32'sd1000000000, 32'sh7fffffff, 32'sh80000001, 32'sh80000000,
        32'sh7ffffffe, 32'sh40000000, 32'shbfffffff, 32'sh55555555, 32'shaaaaaaaa
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    signed_int_to_decimal_ascii_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

    sitd_text_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .value         (value),
        .push          (push),
        .full          (full),
        .char_code     (char_code),
        .last          (last),
        .empty         (empty),
        .pop           (pop),
        .fail_count    (fail_count),
        .pending       (pending),
        .chars_checked (chars_checked)
    );

    always @(negedge clk)
    begin
        pop <= ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic signed [WIDTH-1:0] pick_value();
        longint unsigned  span;
        logic [WIDTH-1:0] r;
        logic             neg;
        neg = $urandom_range(1, 0);
        case ($urandom_range(9, 0))
            0, 1, 2, 3:
            begin
                return $urandom;
            end
            4, 5, 6, 7:
            begin
                span = 1;
                repeat ($urandom_range(10, 1)) span *= 10;
                r = WIDTH'($urandom % span);
            end
            8:
            begin
                return neg ? 32'sh80000000 + $urandom_range(2, 0)
                           : 32'sh7fffffff - $urandom_range(2, 0);
            end
            default:
            begin
                span = 1;
                repeat ($urandom_range(9, 0)) span *= 10;
                r = WIDTH'(span) + WIDTH'($urandom_range(2, 0)) - 1'b1;
            end
        endcase
        if (neg)
        begin
            r = ~r + 1'b1;
        end
        return r;
    endfunction

    task automatic send_number(input logic signed [WIDTH-1:0] v);
        @(negedge clk);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            push  <= 1'b0;
            value <= $urandom;
            @(negedge clk);
        end
        push  <= 1'b1;
        value <= v;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        item_count++;
        if (v < 0)
        begin
            neg_count++;
        end
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (PER_PHASE) send_number(pick_value());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_values[i])
        begin
            send_number(directed_values[i]);
        end

        run_phase(0, 0);
        run_phase(62, 0);
        run_phase(0, 62);
        run_phase(21, 21);

        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);

        $display("Converted %0d numbers (%0d negative) into %0d checked characters",
                 item_count, neg_count, chars_checked);
        $display("across free-flowing, sender-idle, receiver-stall and mixed phases");
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
